### design/nhbc_pkg.sv
package nhbc_pkg;

   // Default widths and the fixed widths of the stream fields.
   localparam int DEF_COEF_WIDTH = 18;
   localparam int DEF_DATA_WIDTH = 32;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int SAMPLE_SHIFT   = 8;
   localparam int OUT_WIDTH      = 32;
   localparam int NUM_SECT       = 2;
   localparam int CSR_IDX_W      = 3;
   localparam int STEP_W         = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOTCH_FB    = 3'd0,
      CSR_NOTCH_FF    = 3'd1,
      CSR_NOTCH_LAST  = 3'd2,
      CSR_HPASS_FB    = 3'd3,
      CSR_HPASS_FF    = 3'd4,
      CSR_HPASS_LAST  = 3'd5
   } csr_index_type;

   // Multiplier coefficient operand.
   typedef enum logic [2:0] {
      COEF_ONE,
      COEF_A1,
      COEF_A2,
      COEF_B0,
      COEF_B1,
      COEF_B2
   } coef_sel_type;

   // Multiplier data operand.
   typedef enum logic [1:0] {
      DATA_X,
      DATA_D1,
      DATA_D2,
      DATA_W
   } data_sel_type;

   // Accumulator operation on the registered product.
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   // Write-back of the rounded accumulator.
   typedef enum logic [1:0] {
      WB_NONE,
      WB_W,
      WB_Y
   } wb_op_type;

   // Sequencing of the step counter.
   typedef enum logic {
      SEQ_NEXT,
      SEQ_BRANCH
   } seq_op_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // One microcode word.
   typedef struct packed {
      coef_sel_type coef_sel;
      data_sel_type data_sel;
      acc_op_type   acc_op;
      wb_op_type    wb_op;
      seq_op_type   seq_op;
   } ctrl_word_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      ctrl_word_type word;
      logic          sec;
      logic          en;
   } ctrl_type;

   // Program for one biquad section. The feedback sum is formed first, the
   // forward sum takes b0*w last so that w has been written back by then.
   // The last step writes the section output, shifts the delays and branches
   // back for the second section or ends the item.
   function automatic ctrl_word_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{COEF_ONE, DATA_X, ACC_HOLD, WB_NONE, SEQ_NEXT};
      case (step)
         3'd0: w = '{COEF_ONE, DATA_X,  ACC_HOLD, WB_NONE, SEQ_NEXT};
         3'd1: w = '{COEF_A1,  DATA_D1, ACC_LOAD, WB_NONE, SEQ_NEXT};
         3'd2: w = '{COEF_A2,  DATA_D2, ACC_SUB,  WB_NONE, SEQ_NEXT};
         3'd3: w = '{COEF_B1,  DATA_D1, ACC_SUB,  WB_NONE, SEQ_NEXT};
         3'd4: w = '{COEF_B2,  DATA_D2, ACC_LOAD, WB_W,    SEQ_NEXT};
         3'd5: w = '{COEF_B0,  DATA_W,  ACC_ADD,  WB_NONE, SEQ_NEXT};
         3'd6: w = '{COEF_ONE, DATA_X,  ACC_ADD,  WB_NONE, SEQ_NEXT};
         default: w = '{COEF_ONE, DATA_X, ACC_HOLD, WB_Y, SEQ_BRANCH};
      endcase
      return w;
   endfunction

endpackage

### design/notch_highpass_biquad_cascade.sv
// Notch then high-pass filter built from two direct-form-II biquad sections
// that share one multiplier and one accumulator under a small microprogram.
//
// Input channel req_*: one signed 16-bit sample per item in req_tdata.
// Result channel rsp_*: one saturated signed Q23.8 value per item in rsp_tdata.
// Configuration channel csr_*: csr_index picks one of six coefficient
// registers, csr_data carries its value; csr_ready is always high. Write only
// while no item is in flight.
//
// An item is accepted only while the sequencer is idle, so a new sample is not
// taken before the last one is through. It then runs eight microcode steps for
// each section, and its result shows on rsp_tvalid once the final write-back
// step of the second section is done. The ten products go one at a time
// through the single multiplier, between the write-back steps of the program.
//
// Reset clears the delay words, the result valid and the sequencer, and loads
// pass-through coefficients. A result waits in the output register until
// taken; a new item is accepted meanwhile, and it stalls at its final
// write-back step only while the earlier result is still held.
module notch_highpass_biquad_cascade
   import nhbc_pkg::*;
#(
   parameter int COEF_WIDTH = DEF_COEF_WIDTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [SAMPLE_WIDTH-1:0] req_tdata,  // [15:0] sample
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [OUT_WIDTH-1:0]    rsp_tdata,  // [31:0] filtered
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [2*COEF_WIDTH-1:0] csr_data
);

   logic [2*COEF_WIDTH-1:0] fb_cfg   [NUM_SECT];
   logic [2*COEF_WIDTH-1:0] ff_cfg   [NUM_SECT];
   logic [COEF_WIDTH-1:0]   last_cfg [NUM_SECT];
   ctrl_type                ctrl;
   logic                    idle;
   logic                    accept;

   assign req_tready = idle;
   assign accept     = req_tvalid && idle;

   // Coefficient registers.
   nhbc_csr #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .fb_out    (fb_cfg),
      .ff_out    (ff_cfg),
      .last_out  (last_cfg)
   );

   // Microcode sequencer.
   nhbc_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .out_busy (rsp_tvalid && !rsp_tready),
      .idle     (idle),
      .ctrl     (ctrl)
   );

   // Multiply-accumulate datapath and result register.
   nhbc_datapath #(
      .COEF_WIDTH (COEF_WIDTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .load        (accept),
      .sample      (req_tdata),
      .fb_in_cfg   (fb_cfg),
      .ff_in_cfg   (ff_cfg),
      .last_in_cfg (last_cfg),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

### design/nhbc_csr.sv
module nhbc_csr
   import nhbc_pkg::*;
#(
   parameter int COEF_WIDTH = DEF_COEF_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [2*COEF_WIDTH-1:0] csr_data,
   output logic [2*COEF_WIDTH-1:0] fb_out   [NUM_SECT],
   output logic [2*COEF_WIDTH-1:0] ff_out   [NUM_SECT],
   output logic [COEF_WIDTH-1:0]   last_out [NUM_SECT]
);

   localparam int FRAC = COEF_WIDTH - 2;
   localparam logic [2*COEF_WIDTH-1:0] FF_RESET = (2*COEF_WIDTH)'(1) << FRAC;

   logic [2*COEF_WIDTH-1:0] fb_ff   [NUM_SECT];
   logic [2*COEF_WIDTH-1:0] ff_ff   [NUM_SECT];
   logic [COEF_WIDTH-1:0]   last_ff [NUM_SECT];
   logic [2*COEF_WIDTH-1:0] fb_in   [NUM_SECT];
   logic [2*COEF_WIDTH-1:0] ff_in   [NUM_SECT];
   logic [COEF_WIDTH-1:0]   last_in [NUM_SECT];

   // Writes are taken in every cycle.
   assign csr_ready = 1'b1;

   // Register decode; indexes beyond the list are dropped.
   always_comb begin
      fb_in   = fb_ff;
      ff_in   = ff_ff;
      last_in = last_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NOTCH_FB:   fb_in[0]   = csr_data;
            CSR_NOTCH_FF:   ff_in[0]   = csr_data;
            CSR_NOTCH_LAST: last_in[0] = csr_data[COEF_WIDTH-1:0];
            CSR_HPASS_FB:   fb_in[1]   = csr_data;
            CSR_HPASS_FF:   ff_in[1]   = csr_data;
            CSR_HPASS_LAST: last_in[1] = csr_data[COEF_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Reset values give a pass-through in both sections.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SECT; s++) begin
            fb_ff[s]   <= '0;
            ff_ff[s]   <= FF_RESET;
            last_ff[s] <= '0;
         end
      end else begin
         fb_ff   <= fb_in;
         ff_ff   <= ff_in;
         last_ff <= last_in;
      end
   end

   assign fb_out   = fb_ff;
   assign ff_out   = ff_ff;
   assign last_out = last_ff;

endmodule

### design/nhbc_sequencer.sv
module nhbc_sequencer
   import nhbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     out_busy,
   output logic     idle,
   output ctrl_type ctrl
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              sec_ff, sec_in;
   ctrl_word_type     word;
   logic              en;

   // State, step counter and section bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         sec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sec_ff   <= sec_in;
      end
   end

   // Fetch, stall on a held result at the final write-back, and branch.
   always_comb begin
      word     = rom_word(step_ff);
      en       = 1'b0;
      state_in = state_ff;
      step_in  = step_ff;
      sec_in   = sec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               step_in  = '0;
               sec_in   = 1'b0;
            end
         end
         ST_RUN: begin
            en = !(word.seq_op == SEQ_BRANCH && sec_ff && out_busy);
            if (en) begin
               if (word.seq_op == SEQ_NEXT) begin
                  step_in = step_ff + STEP_W'(1);
               end else if (!sec_ff) begin
                  step_in = '0;
                  sec_in  = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign idle      = (state_ff == ST_IDLE);
   assign ctrl.word = word;
   assign ctrl.sec  = sec_ff;
   assign ctrl.en   = en;

endmodule

### design/nhbc_datapath.sv
module nhbc_datapath
   import nhbc_pkg::*;
#(
   parameter int COEF_WIDTH = DEF_COEF_WIDTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_type                ctrl,
   input  logic                    load,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   input  logic [2*COEF_WIDTH-1:0] fb_in_cfg   [NUM_SECT],
   input  logic [2*COEF_WIDTH-1:0] ff_in_cfg   [NUM_SECT],
   input  logic [COEF_WIDTH-1:0]   last_in_cfg [NUM_SECT],
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic [OUT_WIDTH-1:0]    rsp_tdata
);

   localparam int CW    = COEF_WIDTH;
   localparam int DW    = DATA_WIDTH;
   localparam int FRAC  = CW - 2;
   localparam int PW    = CW + DW;
   localparam int ACC_W = PW + 2;
   localparam int RW    = ACC_W - FRAC;
   localparam int XW    = RW + OUT_WIDTH;
   localparam logic signed [CW-1:0]    COEF_UNIT = CW'(1) << FRAC;
   localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1) << (FRAC - 1);

   logic signed [DW-1:0]    x_ff, x_in;
   logic signed [DW-1:0]    w_ff, w_in;
   logic signed [DW-1:0]    d1_ff [NUM_SECT];
   logic signed [DW-1:0]    d2_ff [NUM_SECT];
   logic signed [DW-1:0]    d1_in [NUM_SECT];
   logic signed [DW-1:0]    d2_in [NUM_SECT];
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [OUT_WIDTH-1:0]    out_ff, out_in;
   logic                    valid_ff, valid_in;

   logic signed [CW-1:0]    coef_op;
   logic signed [DW-1:0]    data_op;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [RW-1:0]    rnd_sh;
   logic signed [XW-1:0]    rnd_ext;
   logic signed [DW-1:0]    sat_dw;
   logic [OUT_WIDTH-1:0]    sat_out;
   logic                    ovf_dw, ovf_out;
   logic signed [ACC_W-1:0] prod_ext;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctrl.word.coef_sel)
         COEF_A1: coef_op = $signed(fb_in_cfg[ctrl.sec][CW-1:0]);
         COEF_A2: coef_op = $signed(fb_in_cfg[ctrl.sec][2*CW-1:CW]);
         COEF_B0: coef_op = $signed(ff_in_cfg[ctrl.sec][CW-1:0]);
         COEF_B1: coef_op = $signed(ff_in_cfg[ctrl.sec][2*CW-1:CW]);
         COEF_B2: coef_op = $signed(last_in_cfg[ctrl.sec]);
         default: coef_op = COEF_UNIT;
      endcase
      case (ctrl.word.data_sel)
         DATA_D1: data_op = d1_ff[ctrl.sec];
         DATA_D2: data_op = d2_ff[ctrl.sec];
         DATA_W:  data_op = w_ff;
         default: data_op = x_ff;
      endcase
   end

   // Round half up by the fraction bits, then saturate to both widths.
   always_comb begin
      acc_rnd = acc_ff + RND_HALF;
      rnd_sh  = acc_rnd[ACC_W-1:FRAC];
      rnd_ext = XW'(rnd_sh);
      ovf_dw  = !((&rnd_sh[RW-1:DW-1]) || !(|rnd_sh[RW-1:DW-1]));
      ovf_out = !((&rnd_ext[XW-1:OUT_WIDTH-1]) || !(|rnd_ext[XW-1:OUT_WIDTH-1]));
      if (ovf_dw) begin
         sat_dw = {rnd_sh[RW-1], {(DW-1){!rnd_sh[RW-1]}}};
      end else begin
         sat_dw = rnd_sh[DW-1:0];
      end
      if (ovf_out) begin
         sat_out = {rnd_ext[XW-1], {(OUT_WIDTH-1){!rnd_ext[XW-1]}}};
      end else begin
         sat_out = rnd_ext[OUT_WIDTH-1:0];
      end
   end

   // Next values of the multiplier, accumulator and data registers.
   always_comb begin
      x_in     = x_ff;
      w_in     = w_ff;
      d1_in    = d1_ff;
      d2_in    = d2_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      out_in   = out_ff;
      valid_in = valid_ff && !rsp_tready;
      prod_ext = ACC_W'(prod_ff);
      if (load) begin
         x_in = DW'($signed(sample)) <<< SAMPLE_SHIFT;
      end
      if (ctrl.en) begin
         prod_in = PW'(coef_op) * PW'(data_op);
         case (ctrl.word.acc_op)
            ACC_LOAD: acc_in = prod_ext;
            ACC_ADD:  acc_in = acc_ff + prod_ext;
            ACC_SUB:  acc_in = acc_ff - prod_ext;
            default:  acc_in = acc_ff;
         endcase
         case (ctrl.word.wb_op)
            WB_W: w_in = sat_dw;
            WB_Y: begin
               d2_in[ctrl.sec] = d1_ff[ctrl.sec];
               d1_in[ctrl.sec] = w_ff;
               if (!ctrl.sec) begin
                  x_in = sat_dw;
               end else begin
                  out_in   = sat_out;
                  valid_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Delay words and result valid are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SECT; s++) begin
            d1_ff[s] <= '0;
            d2_ff[s] <= '0;
         end
         valid_ff <= 1'b0;
      end else begin
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

### design/nhbc_checker.sv
module nhbc_checker
   import nhbc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [OUT_WIDTH-1:0] rsp_tdata
);

   // One item at a time: ready drops right after an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item was in flight");

   // A new result only appears at the end of a busy period.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared with no item in flight");

   // No result is shown right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A held result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held result changed");

endmodule

bind notch_highpass_biquad_cascade nhbc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
